### sv/pidf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidf_pkg;

    localparam int DATA_W     = 32;
    localparam int OPND_W     = DATA_W + 1;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int ACC_W      = 64;
    localparam int INTEG_W    = 48;
    localparam int SPLIT_W    = 24;
    localparam int KI_SAT_EXP = 60;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ALPHA_W-1:0]       alpha_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam alpha_t ALPHA_ONE = alpha_t'(1) << ALPHA_FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP,
        REG_GAIN_INTEG,
        REG_GAIN_DERIV,
        REG_LIMIT_LOW,
        REG_LIMIT_HIGH,
        REG_SMOOTH_ALPHA,
        REG_DERIV_ON_MEAS
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_E_DT,
        MUL_KP_E,
        MUL_KI_LO,
        MUL_KI_HI,
        MUL_A_RAW,
        MUL_NA_D,
        MUL_KD_D
    } mul_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_ITEM,
        OP_CLEAR,
        OP_ZERO,
        OP_START,
        OP_INTEG,
        OP_KP,
        OP_KI_LO,
        OP_KI_HI,
        OP_KI_ADD,
        OP_FILT_LOAD,
        OP_FILT_UPD,
        OP_KD_ADD,
        OP_CLAMP
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_INTEG,
        S_KP,
        S_KI_LO,
        S_KI_HI,
        S_KI_ADD,
        S_DIV_WAIT,
        S_FILT_A,
        S_FILT_B,
        S_FILT_C,
        S_KD,
        S_KD_ADD,
        S_CLAMP,
        S_FINISH
    } ctl_state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        dp_op_t   op;
        logic     div_start;
        logic     load_out;
    } pidf_cmd_t;

    typedef struct packed {
        logic mode_reset;
        logic dt_bad;
        logic div_done;
    } pidf_status_t;

endpackage

`default_nettype wire

### sv/pidf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pidf_sample_if
    import pidf_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  mode;
    data_t error_in;
    data_t meas_in;
    data_t time_step;

    modport source (output valid, output mode, output error_in, output meas_in,
                    output time_step, input ready);
    modport sink   (input valid, input mode, input error_in, input meas_in,
                    input time_step, output ready);
endinterface

interface pidf_result_if
    import pidf_pkg::*;
;
    logic  valid;
    logic  ready;
    data_t drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface pidf_cfg_if
    import pidf_pkg::*;
;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/pidf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pidf_div
    import pidf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [OPND_W-1:0] num,
    input  data_t                    den,
    output logic                     done,
    output data_t                    quot
);

    localparam int QW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(QW);

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    data_t             quot_reg, quot_next;

    logic signed [OPND_W-1:0] num_abs;
    logic [DATA_W-1:0]        rem_sh;
    logic [DATA_W:0]          diff;
    logic                     q_big;

    assign num_abs = num[OPND_W-1] ? -num : num;
    assign rem_sh  = {rem_reg[DATA_W-2:0], q_reg[QW-1]};
    assign diff    = {1'b0, rem_sh} - {1'b0, den_reg};
    assign q_big   = (q_reg[QW-1:DATA_W-1] != '0);

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            neg_next  = num[OPND_W-1];
            q_next    = {num_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // sign and saturate to 32 bits
            done_next = 1'b1;
            if (!neg_reg)
                quot_next = q_big ? data_t'({1'b0, {(DATA_W-1){1'b1}}})
                                  : data_t'(q_reg[DATA_W-1:0]);
            else
                quot_next = q_big ? data_t'({1'b1, {(DATA_W-1){1'b0}}})
                                  : -$signed(q_reg[DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### sv/pidf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pidf_dp
    import pidf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  pidf_cmd_t    cmd,
    output pidf_status_t status,
    input  logic         cfg_write,
    input  cfg_idx_t     cfg_index,
    input  data_t        cfg_data,
    input  logic         mode,
    input  data_t        error_in,
    input  data_t        meas_in,
    input  data_t        time_step,
    output data_t        drive
);

    localparam int KI_SHIFT = SPLIT_W - FRAC_BITS;

    localparam logic signed [PROD_W-1:0] I_MAX = PROD_W'({1'b0, {(INTEG_W-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] I_MIN = -I_MAX - 1;
    localparam logic signed [PROD_W-1:0] D_MAX = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] D_MIN = -D_MAX - 1;
    localparam logic signed [PROD_W-1:0] KI_BOUND   = PROD_W'(1) <<< (KI_SAT_EXP - KI_SHIFT);
    localparam logic signed [PROD_W-1:0] KI_BOUND_N = -KI_BOUND;
    localparam logic signed [ACC_W-1:0]  KI_SAT     = ACC_W'(1) <<< KI_SAT_EXP;

    function automatic logic signed [OPND_W-1:0] ext_o(input data_t v);
        ext_o = {v[DATA_W-1], v};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_a(input data_t v);
        ext_a = {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // configuration
    data_t  gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    data_t  limit_low_reg, limit_high_reg;
    alpha_t alpha_reg;
    logic   dmeas_reg;

    // controller state
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    data_t                     last_error_reg, last_error_next;
    data_t                     last_meas_reg, last_meas_next;
    data_t                     deriv_reg, deriv_next;

    // working registers
    logic                     mode_reg, mode_next;
    data_t                    error_reg, error_next;
    data_t                    meas_reg, meas_next;
    data_t                    dt_reg, dt_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] f_reg, f_next;
    logic signed [ACC_W-1:0]  u_reg, u_next;
    logic signed [ACC_W-1:0]  w_reg, w_next;
    data_t                    y_reg, y_next;
    data_t                    drive_reg, drive_next;

    logic signed [OPND_W-1:0] opa, opb;
    logic signed [OPND_W-1:0] div_num;
    logic signed [PROD_W-1:0] prod_sh, isum, fsum, fsh, ki_sh;
    alpha_t                   alpha_c, alpha_n;
    data_t                    lim_lo, lim_hi;
    logic                     div_done;
    data_t                    raw;

    assign alpha_c = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_n = ALPHA_ONE - alpha_c;
    assign lim_lo  = (limit_low_reg > limit_high_reg) ? limit_high_reg : limit_low_reg;
    assign lim_hi  = (limit_low_reg > limit_high_reg) ? limit_low_reg : limit_high_reg;

    assign div_num = dmeas_reg ? (ext_o(meas_reg) - ext_o(last_meas_reg))
                               : (ext_o(error_reg) - ext_o(last_error_reg));

    pidf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (dt_reg),
        .done  (div_done),
        .quot  (raw)
    );

    // shared multiplier operands
    always_comb
    begin
        opa = ext_o(error_reg);
        opb = ext_o(dt_reg);
        case (cmd.mul_sel)
            MUL_E_DT:
            begin
                opa = ext_o(error_reg);
                opb = ext_o(dt_reg);
            end
            MUL_KP_E:
            begin
                opa = ext_o(gain_prop_reg);
                opb = ext_o(error_reg);
            end
            MUL_KI_LO:
            begin
                opa = ext_o(gain_integ_reg);
                opb = $signed({{(OPND_W-SPLIT_W){1'b0}}, integ_reg[SPLIT_W-1:0]});
            end
            MUL_KI_HI:
            begin
                opa = ext_o(gain_integ_reg);
                opb = $signed({{(OPND_W-INTEG_W+SPLIT_W){integ_reg[INTEG_W-1]}},
                               integ_reg[INTEG_W-1:SPLIT_W]});
            end
            MUL_A_RAW:
            begin
                opa = $signed({{(OPND_W-ALPHA_W){1'b0}}, alpha_c});
                opb = ext_o(raw);
            end
            MUL_NA_D:
            begin
                opa = $signed({{(OPND_W-ALPHA_W){1'b0}}, alpha_n});
                opb = ext_o(deriv_reg);
            end
            MUL_KD_D:
            begin
                opa = ext_o(gain_deriv_reg);
                opb = ext_o(deriv_reg);
            end
            default:
            begin
                opa = ext_o(error_reg);
                opb = ext_o(dt_reg);
            end
        endcase
    end

    assign prod_next = opa * opb;
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign isum      = $signed({{(PROD_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}) + prod_sh;
    assign fsum      = f_reg + prod_reg;
    assign fsh       = fsum >>> ALPHA_FRAC;
    assign ki_sh     = prod_reg <<< KI_SHIFT;

    always_comb
    begin
        mode_next       = mode_reg;
        error_next      = error_reg;
        meas_next       = meas_reg;
        dt_next         = dt_reg;
        integ_next      = integ_reg;
        last_error_next = last_error_reg;
        last_meas_next  = last_meas_reg;
        deriv_next      = deriv_reg;
        f_next          = f_reg;
        u_next          = u_reg;
        w_next          = w_reg;
        y_next          = y_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD_ITEM:
            begin
                mode_next  = mode;
                error_next = error_in;
                meas_next  = meas_in;
                dt_next    = time_step;
            end
            OP_CLEAR:
            begin
                integ_next      = '0;
                last_error_next = '0;
                deriv_next      = '0;
                last_meas_next  = meas_reg;
                y_next          = '0;
            end
            OP_ZERO:
            begin
                y_next = '0;
            end
            OP_START:
            begin
                if (dmeas_reg)
                    last_meas_next = meas_reg;
                else
                    last_error_next = error_reg;
            end
            OP_INTEG:
            begin
                if (isum > I_MAX)
                    integ_next = I_MAX[INTEG_W-1:0];
                else if (isum < I_MIN)
                    integ_next = I_MIN[INTEG_W-1:0];
                else
                    integ_next = isum[INTEG_W-1:0];
            end
            OP_KP:
            begin
                u_next = prod_sh[ACC_W-1:0];
            end
            OP_KI_LO:
            begin
                w_next = prod_sh[ACC_W-1:0];
            end
            OP_KI_HI:
            begin
                if (prod_reg > KI_BOUND)
                    w_next = KI_SAT;
                else if (prod_reg < KI_BOUND_N)
                    w_next = -KI_SAT;
                else
                    w_next = $signed(ki_sh[ACC_W-1:0]) + w_reg;
            end
            OP_KI_ADD:
            begin
                u_next = u_reg + w_reg;
            end
            OP_FILT_LOAD:
            begin
                f_next = prod_reg;
            end
            OP_FILT_UPD:
            begin
                if (fsh > D_MAX)
                    deriv_next = D_MAX[DATA_W-1:0];
                else if (fsh < D_MIN)
                    deriv_next = D_MIN[DATA_W-1:0];
                else
                    deriv_next = fsh[DATA_W-1:0];
            end
            OP_KD_ADD:
            begin
                if (dmeas_reg)
                    u_next = u_reg - $signed(prod_sh[ACC_W-1:0]);
                else
                    u_next = u_reg + $signed(prod_sh[ACC_W-1:0]);
            end
            OP_CLAMP:
            begin
                if (u_reg > ext_a(lim_hi))
                    y_next = lim_hi;
                else if (u_reg < ext_a(lim_lo))
                    y_next = lim_lo;
                else
                    y_next = u_reg[DATA_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign drive_next = cmd.load_out ? y_reg : drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            limit_low_reg  <= data_t'({1'b1, {(DATA_W-1){1'b0}}});
            limit_high_reg <= data_t'({1'b0, {(DATA_W-1){1'b1}}});
            alpha_reg      <= ALPHA_ONE;
            dmeas_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_PROP:     gain_prop_reg  <= cfg_data;
                REG_GAIN_INTEG:    gain_integ_reg <= cfg_data;
                REG_GAIN_DERIV:    gain_deriv_reg <= cfg_data;
                REG_LIMIT_LOW:     limit_low_reg  <= cfg_data;
                REG_LIMIT_HIGH:    limit_high_reg <= cfg_data;
                REG_SMOOTH_ALPHA:  alpha_reg      <= cfg_data[ALPHA_W-1:0];
                REG_DERIV_ON_MEAS: dmeas_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg      <= '0;
            last_error_reg <= '0;
            last_meas_reg  <= '0;
            deriv_reg      <= '0;
        end
        else
        begin
            integ_reg      <= integ_next;
            last_error_reg <= last_error_next;
            last_meas_reg  <= last_meas_next;
            deriv_reg      <= deriv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        error_reg <= error_next;
        meas_reg  <= meas_next;
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
        f_reg     <= f_next;
        u_reg     <= u_next;
        w_reg     <= w_next;
        y_reg     <= y_next;
        drive_reg <= drive_next;
    end

    assign status.mode_reset = mode_reg;
    assign status.dt_bad     = dt_reg[DATA_W-1] | (dt_reg == '0);
    assign status.div_done   = div_done;
    assign drive             = drive_reg;

endmodule

`default_nettype wire

### sv/pidf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pidf_ctrl
    import pidf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_ready,
    output logic         result_valid,
    input  logic         result_ready,
    input  pidf_status_t status,
    output pidf_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (sample_valid) state_next = S_CHECK;
            S_CHECK:    state_next = (status.mode_reset || status.dt_bad) ? S_FINISH : S_START;
            S_START:    state_next = S_INTEG;
            S_INTEG:    state_next = S_KP;
            S_KP:       state_next = S_KI_LO;
            S_KI_LO:    state_next = S_KI_HI;
            S_KI_HI:    state_next = S_KI_ADD;
            S_KI_ADD:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (status.div_done) state_next = S_FILT_A;
            S_FILT_A:   state_next = S_FILT_B;
            S_FILT_B:   state_next = S_FILT_C;
            S_FILT_C:   state_next = S_KD;
            S_KD:       state_next = S_KD_ADD;
            S_KD_ADD:   state_next = S_CLAMP;
            S_CLAMP:    state_next = S_FINISH;
            S_FINISH:   if (slot_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.mul_sel   = MUL_E_DT;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.load_out  = 1'b0;
        sample_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                    cmd.op = OP_LOAD_ITEM;
            end
            S_CHECK:
            begin
                if (status.mode_reset)
                    cmd.op = OP_CLEAR;
                else if (status.dt_bad)
                    cmd.op = OP_ZERO;
            end
            S_START:
            begin
                cmd.mul_sel   = MUL_E_DT;
                cmd.op        = OP_START;
                cmd.div_start = 1'b1;
            end
            S_INTEG:
            begin
                cmd.op      = OP_INTEG;
                cmd.mul_sel = MUL_KP_E;
            end
            S_KP:
            begin
                cmd.op      = OP_KP;
                cmd.mul_sel = MUL_KI_LO;
            end
            S_KI_LO:
            begin
                cmd.op      = OP_KI_LO;
                cmd.mul_sel = MUL_KI_HI;
            end
            S_KI_HI:    cmd.op = OP_KI_HI;
            S_KI_ADD:   cmd.op = OP_KI_ADD;
            S_DIV_WAIT: cmd.op = OP_NONE;
            S_FILT_A:   cmd.mul_sel = MUL_A_RAW;
            S_FILT_B:
            begin
                cmd.op      = OP_FILT_LOAD;
                cmd.mul_sel = MUL_NA_D;
            end
            S_FILT_C:   cmd.op = OP_FILT_UPD;
            S_KD:       cmd.mul_sel = MUL_KD_D;
            S_KD_ADD:   cmd.op = OP_KD_ADD;
            S_CLAMP:    cmd.op = OP_CLAMP;
            S_FINISH:   cmd.load_out = slot_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

### sv/pid_with_filtered_derivative_core.sv
// one word in flight at a time: a new word is taken only after the last result is
//   loaded into the output register; the derivative uses the radix-2 divide by the
//   time step, one quotient bit per cycle over 32 + FRAC_BITS bits
// reset or bad time step words go from S_CHECK straight to S_FINISH and return 0
// rst_n clears the controller and handshake state and resets the config registers
`timescale 1ns / 1ps
`default_nettype none

module pid_with_filtered_derivative_core
    import pidf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    pidf_sample_if.sink   sample,
    pidf_result_if.source result,
    pidf_cfg_if.sink      cfg
);

    pidf_cmd_t    cmd;
    pidf_status_t status;

    assign cfg.ready = 1'b1;

    pidf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    pidf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg.valid & cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .mode      (sample.mode),
        .error_in  (sample.error_in),
        .meas_in   (sample.meas_in),
        .time_step (sample.time_step),
        .drive     (result.drive)
    );

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("new word taken while one is in flight");

    a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider done flag not cleared on start");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.load_out))
        else $error("result valid without output load");

    a_load_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sample.ready)
        else $error("output load while input side open");

endmodule

`default_nettype wire
